FILE: hdl/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types, constants and character classifiers for the expression
// token lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

   // Size limits of the source text
   localparam int MAX_LINE_LEN = 4096;
   localparam int MAX_LINES    = 65536;

   localparam int LINE_CAP_INT = (MAX_LINES < 65535) ? MAX_LINES : 65535;
   localparam int COL_CAP_INT  = ((MAX_LINE_LEN - 1) < 4095) ? (MAX_LINE_LEN - 1) : 4095;

   localparam logic [15:0] LINE_CAP = 16'(LINE_CAP_INT);
   localparam logic [11:0] COL_CAP  = 12'(COL_CAP_INT);
   localparam logic [11:0] LEN_CAP  = 12'hFFF;

   // Token queue between scanner and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Keyword match progress
   localparam logic [2:0] KP_NONE  = 3'd0;
   localparam logic [2:0] KP_FIRST = 3'd1;
   localparam logic [2:0] KP_MATCH = 3'd3;
   localparam logic [2:0] KP_FAIL  = 3'd4;

   // Source bytes
   localparam logic [7:0] CH_ASSIGN = 8'h3D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_ADD    = 8'h2B;
   localparam logic [7:0] CH_SUB    = 8'h2D;
   localparam logic [7:0] CH_MUL    = 8'h2A;
   localparam logic [7:0] CH_DIV    = 8'h2F;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_L      = 8'h6C;
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_T      = 8'h74;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_WS    = 3'd1,
      MODE_IDENT = 3'd2,
      MODE_NUM   = 3'd3,
      MODE_STR   = 3'd4
   } scan_mode_type;

   typedef enum logic [3:0] {
      TK_ASSIGN = 4'd0,
      TK_LPAREN = 4'd1,
      TK_RPAREN = 4'd2,
      TK_ADD    = 4'd3,
      TK_SUB    = 4'd4,
      TK_MUL    = 4'd5,
      TK_DIV    = 4'd6,
      TK_WS     = 4'd7,
      TK_LET    = 4'd8,
      TK_IDENT  = 4'd9,
      TK_NUMBER = 4'd10,
      TK_ERROR  = 4'd11
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [15:0]    line;
      logic [11:0]    start;
      logic [11:0]    length;
      logic           last;
   } token_type;

   // Tokens caused by one request: one or two
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two;
   } entry_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_UNDER;
   endfunction

   function automatic logic is_decimal(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == CH_ASSIGN || c == CH_LPAREN || c == CH_RPAREN || c == CH_ADD ||
             c == CH_SUB || c == CH_MUL || c == CH_DIV;
   endfunction

   function automatic token_kind_type op_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         CH_ASSIGN: k = TK_ASSIGN;
         CH_LPAREN: k = TK_LPAREN;
         CH_RPAREN: k = TK_RPAREN;
         CH_ADD:    k = TK_ADD;
         CH_SUB:    k = TK_SUB;
         CH_MUL:    k = TK_MUL;
         CH_DIV:    k = TK_DIV;
         default:   k = TK_ERROR;
      endcase
      return k;
   endfunction

   // Expected byte of the keyword at a given progress
   function automatic logic [7:0] kw_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0:    ch = CH_L;
         2'd1:    ch = CH_E;
         default: ch = CH_T;
      endcase
      return ch;
   endfunction

endpackage

FILE: hdl/etl_if.sv
// ----------------------------------------------------------------------------
// etl_req_if / etl_rsp_if
// Valid/ready channels for source requests and token results.
// ----------------------------------------------------------------------------
interface etl_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_code;

   modport source (output valid, req_type, char_code, input ready);
   modport sink   (input valid, req_type, char_code, output ready);
endinterface

interface etl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [15:0] line_number;
   logic [11:0] start_column;
   logic [11:0] token_length;
   logic        last_result;

   modport source (output valid, token_kind, line_number, start_column, token_length,
                   last_result, input ready);
   modport sink   (input valid, token_kind, line_number, start_column, token_length,
                   last_result, output ready);
endinterface

FILE: hdl/expression_token_lexer.sv
// A completed token is written to the queue, then registered for output on rsp.
// One request per cycle while the queue has room; the output register moves one
// token per cycle while rsp is ready, a pair one at a time (queue of 4 entries).
// Reset: synchronous, active high; clears the pending token, sets line to 1 and
// column to 0, and empties the queue and output register.
// ----------------------------------------------------------------------------
// expression_token_lexer
// Byte-stream tokenizer: scanner front end, entry queue, token emitter.
// ----------------------------------------------------------------------------
module expression_token_lexer
   import etl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   etl_req_if.sink   req_port,
   etl_rsp_if.source rsp_port
);

   logic      push, pop, not_full, not_empty;
   entry_type push_entry, head;

   etl_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .queue_ready (not_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   etl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .not_full   (not_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   etl_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_port   (rsp_port)
   );

endmodule

FILE: hdl/etl_scanner.sv
// ----------------------------------------------------------------------------
// etl_scanner
// Front end: accepts one request per cycle while the queue has room, tracks the
// pending token and the line/column position, and writes completed tokens to the queue.
// ----------------------------------------------------------------------------
module etl_scanner
   import etl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   etl_req_if.sink   req_port,
   input  logic      queue_ready,
   output logic      push,
   output entry_type push_entry
);

   scan_mode_type mode_ff, mode_in;
   logic [11:0]   start_ff, start_in;
   logic [11:0]   len_ff, len_in;
   logic [2:0]    kp_ff, kp_in;
   logic [15:0]   line_ff, line_in;
   logic [11:0]   col_ff, col_in;

   logic          accept;
   logic [7:0]    c;
   logic [11:0]   len_ext;
   logic          flush_en, fresh_en, do_fresh, fresh_single;
   token_type     flush_tok, fresh_tok;

   assign req_port.ready = queue_ready;
   assign accept         = req_port.valid && queue_ready;
   assign c              = req_port.char_code;
   assign len_ext        = (len_ff < LEN_CAP) ? len_ff + 12'd1 : len_ff;

   // Hold scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         kp_ff    <= KP_NONE;
         line_ff  <= 16'd1;
         col_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kp_ff    <= kp_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
      end
   end

   // Classify the byte, advance the pending token, collect completed tokens
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      len_in   = len_ff;
      kp_in    = kp_ff;
      line_in  = line_ff;
      col_in   = col_ff;

      flush_tok.line   = line_ff;
      flush_tok.start  = start_ff;
      flush_tok.length = len_ff;
      flush_tok.last   = 1'b0;
      unique case (mode_ff)
         MODE_WS:    flush_tok.kind = TK_WS;
         MODE_IDENT: flush_tok.kind = (kp_ff == KP_MATCH) ? TK_LET : TK_IDENT;
         MODE_NUM:   flush_tok.kind = TK_NUMBER;
         MODE_STR:   flush_tok.kind = TK_IDENT;
         default:    flush_tok.kind = TK_ERROR;
      endcase

      fresh_single     = is_op(c) || !(is_space(c) || is_alpha(c) ||
                         (is_decimal(c) && c != CH_ZERO) || c == CH_QUOTE);
      fresh_tok.kind   = is_op(c) ? op_kind(c) : ((c == CH_ZERO) ? TK_NUMBER : TK_ERROR);
      fresh_tok.line   = line_ff;
      fresh_tok.start  = col_ff;
      fresh_tok.length = 12'd1;
      fresh_tok.last   = 1'b0;

      flush_en = 1'b0;
      fresh_en = 1'b0;
      do_fresh = 1'b0;

      if (accept) begin
         if (req_port.req_type) begin
            // End of line: flush, next line, column back to zero
            flush_en = (mode_ff != MODE_IDLE);
            mode_in  = MODE_IDLE;
            start_in = '0;
            len_in   = '0;
            kp_in    = KP_NONE;
            line_in  = (line_ff < LINE_CAP) ? line_ff + 16'd1 : line_ff;
            col_in   = '0;
         end else begin
            unique case (mode_ff)
               MODE_STR: begin
                  if (c == CH_CR || c == CH_LF) begin
                     flush_en = 1'b1;
                     do_fresh = 1'b1;
                  end else begin
                     len_in = len_ext;
                     if (c == CH_QUOTE) begin
                        flush_en         = 1'b1;
                        flush_tok.length = len_ext;
                        mode_in          = MODE_IDLE;
                        start_in         = '0;
                        len_in           = '0;
                        kp_in            = KP_NONE;
                     end
                  end
               end
               MODE_WS: begin
                  if (is_space(c)) begin
                     len_in = len_ext;
                  end else begin
                     flush_en = 1'b1;
                     do_fresh = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (is_alpha(c) || is_decimal(c)) begin
                     len_in = len_ext;
                     if (kp_ff < KP_MATCH && c == kw_char(kp_ff[1:0])) begin
                        kp_in = kp_ff + 3'd1;
                     end else begin
                        kp_in = KP_FAIL;
                     end
                  end else begin
                     flush_en = 1'b1;
                     do_fresh = 1'b1;
                  end
               end
               MODE_NUM: begin
                  if (is_decimal(c)) begin
                     len_in = len_ext;
                  end else begin
                     flush_en = 1'b1;
                     do_fresh = 1'b1;
                  end
               end
               default: begin
                  do_fresh = 1'b1;
               end
            endcase

            // Start a new token from this byte
            if (do_fresh) begin
               mode_in  = MODE_IDLE;
               start_in = '0;
               len_in   = '0;
               kp_in    = KP_NONE;
               if (fresh_single) begin
                  fresh_en = 1'b1;
               end else begin
                  start_in = col_ff;
                  len_in   = 12'd1;
                  if (is_space(c)) begin
                     mode_in = MODE_WS;
                  end else if (is_alpha(c)) begin
                     mode_in = MODE_IDENT;
                     kp_in   = (c == CH_L) ? KP_FIRST : KP_FAIL;
                  end else if (c == CH_QUOTE) begin
                     mode_in = MODE_STR;
                  end else begin
                     mode_in = MODE_NUM;
                  end
               end
            end

            col_in = (col_ff < COL_CAP) ? col_ff + 12'd1 : col_ff;
         end
      end

      // Pack one or two tokens, marking the last
      push            = flush_en || fresh_en;
      push_entry.two  = flush_en && fresh_en;
      push_entry.tok0 = flush_en ? flush_tok : fresh_tok;
      push_entry.tok1 = fresh_tok;
      push_entry.tok0.last = !(flush_en && fresh_en);
      push_entry.tok1.last = 1'b1;
   end

endmodule

FILE: hdl/etl_queue.sv
// ----------------------------------------------------------------------------
// etl_queue
// Short FIFO of token entries between the scanner and the emitter.
// ----------------------------------------------------------------------------
module etl_queue
   import etl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      not_full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   entry_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign not_full  = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hdl/etl_emitter.sv
// ----------------------------------------------------------------------------
// etl_emitter
// Back end: unpacks queue entries into single tokens and holds each in the
// output register until the result channel takes it.
// ----------------------------------------------------------------------------
module etl_emitter
   import etl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      pop,
   etl_rsp_if.source rsp_port
);

   logic      valid_ff, valid_in;
   logic      phase_ff, phase_in;
   token_type tok_ff, tok_in;
   logic      load;

   assign load = (!valid_ff || rsp_port.ready) && head_valid;

   // Pick the next token, pop the entry after its final token
   always_comb begin
      tok_in   = tok_ff;
      phase_in = phase_ff;
      valid_in = valid_ff;
      pop      = 1'b0;
      if (load) begin
         tok_in   = phase_ff ? head.tok1 : head.tok0;
         valid_in = 1'b1;
         pop      = phase_ff || !head.two;
         phase_in = !phase_ff && head.two;
      end else if (rsp_port.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign rsp_port.valid        = valid_ff;
   assign rsp_port.token_kind   = tok_ff.kind;
   assign rsp_port.line_number  = tok_ff.line;
   assign rsp_port.start_column = tok_ff.start;
   assign rsp_port.token_length = tok_ff.length;
   assign rsp_port.last_result  = tok_ff.last;

endmodule
